### design/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the separator field splitter
// Holds the configuration register indexes, the result record and the
// record that hands finished results from the split core to the result queue.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Default parameter values.
  localparam int SEP_MAX_DEF  = 8;
  localparam int OFFSET_W_DEF = 32;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int RES_W      = 32;
  localparam int LEN_W      = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEP_BYTES = 1'b0,
    CFG_SEP_LEN   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [RES_W-1:0] part_start;
    logic [RES_W-1:0] part_length;
    logic             last_part;
  } result_t;

  // Up to two results per input byte, res0 first.
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

### design/separator_field_splitter_core.sv
// A byte taken into the input register waits there while the result queue
// lacks room, then its results are written into the queue, which offers them in order.
// Throughput: one byte per cycle while the output takes one transfer per cycle;
// a byte that yields two results hands both over the single output port in turn.
// Reset: synchronous, active low; clears the byte window, position, open part
// start, the result queue and the configuration (separator length one).
// ----------------------------------------------------------------------------
// separator_field_splitter_core: byte stream splitter on a multibyte separator
// Input register, split core with a parallel window compare, and a small
// result queue that parts the input side from the output side.
// ----------------------------------------------------------------------------
module separator_field_splitter_core
  import sfs_pkg::*;
#(
  parameter int SEP_MAX  = SEP_MAX_DEF,
  parameter int OFFSET_W = OFFSET_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  in_final_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RES_W-1:0]      out_part_start,
  output logic [RES_W-1:0]      out_part_length,
  output logic                  out_last_part
);

  logic [CFG_DATA_W-1:0] sep_bytes_r;
  logic [LEN_W-1:0]      sep_len_r;

  logic                  item_vld_r;
  logic [BYTE_W-1:0]     item_byte_r;
  logic                  item_fin_r;

  logic                  advance;
  logic                  q_space;
  logic                  q_not_empty;
  logic                  pop;
  push_t                 push;
  result_t               head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes_r <= '0;
      sep_len_r   <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEP_BYTES: sep_bytes_r <= cfg_wdata;
        CFG_SEP_LEN:   sep_len_r   <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  // The held byte moves on whenever the queue can take its results.
  assign advance  = item_vld_r && q_space;
  assign in_stall = item_vld_r && !q_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_byte_r <= in_data_byte;
      item_fin_r  <= in_final_byte;
    end
  end

  sfs_split_core #(
    .SEP_MAX  (SEP_MAX),
    .OFFSET_W (OFFSET_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (advance),
    .data_byte  (item_byte_r),
    .final_byte (item_fin_r),
    .sep_bytes  (sep_bytes_r),
    .sep_len    (sep_len_r),
    .push       (push)
  );

  assign pop = q_not_empty && !out_stall;

  sfs_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .space     (q_space)
  );

  assign out_valid       = q_not_empty;
  assign out_part_start  = head.part_start;
  assign out_part_length = head.part_length;
  assign out_last_part   = head.last_part;

endmodule

### design/sfs_split_core.sv
// ----------------------------------------------------------------------------
// sfs_split_core: separator search and part bookkeeping
// Holds the recent byte window, the byte position and the start of the open
// part. For each byte it compares the window against the separator for every
// possible length in parallel and produces zero, one or two results.
// ----------------------------------------------------------------------------
module sfs_split_core
  import sfs_pkg::*;
#(
  parameter int SEP_MAX  = SEP_MAX_DEF,
  parameter int OFFSET_W = OFFSET_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_vld,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic                  final_byte,
  input  logic [CFG_DATA_W-1:0] sep_bytes,
  input  logic [LEN_W-1:0]      sep_len,
  output push_t                 push
);

  localparam logic [OFFSET_W-1:0] POS_MAX = {OFFSET_W{1'b1}};

  logic [BYTE_W-1:0]   win_r   [SEP_MAX];
  logic [BYTE_W-1:0]   win_nxt [SEP_MAX];
  logic [OFFSET_W-1:0] pos_r, pos_nxt;
  logic [OFFSET_W-1:0] ops_r, ops_nxt;

  logic [LEN_W-1:0]    len_eff;
  logic [OFFSET_W-1:0] len_ext;
  logic [SEP_MAX:0]    match_by_len;
  logic                win_hit;
  logic                can_match;
  logic                sep_hit;
  logic [OFFSET_W-1:0] end_pos;
  logic [OFFSET_W-1:0] span;
  logic [OFFSET_W-1:0] ops_after;
  logic [OFFSET_W-1:0] rem;
  result_t             res_match;
  result_t             res_fin;
  push_t               push_c;

  // Lengths above the window depth behave as the full window.
  assign len_eff = (sep_len > LEN_W'(SEP_MAX)) ? LEN_W'(SEP_MAX) : sep_len;
  assign len_ext = OFFSET_W'(len_eff);

  always_comb begin
    win_nxt[0] = data_byte;
    for (int k = 1; k < SEP_MAX; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // Separator byte 0 is the oldest of the last l bytes.
  always_comb begin
    match_by_len = '0;
    for (int l = 1; l <= SEP_MAX; l++) begin
      match_by_len[l] = 1'b1;
      for (int j = 0; j < SEP_MAX; j++) begin
        if (j < l) begin
          if (win_nxt[l-1-j] != sep_bytes[BYTE_W*j +: BYTE_W]) begin
            match_by_len[l] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    win_hit = 1'b0;
    for (int l = 1; l <= SEP_MAX; l++) begin
      if (len_eff == LEN_W'(l)) begin
        win_hit = match_by_len[l];
      end
    end
  end

  assign end_pos   = (pos_r == POS_MAX) ? POS_MAX : pos_r + 1'b1;
  assign span      = end_pos - ops_r;
  assign can_match = (ops_r <= end_pos) && (span >= len_ext) && (pos_r != POS_MAX);
  assign sep_hit   = can_match && win_hit && (len_eff != '0);
  assign ops_after = sep_hit ? end_pos : ops_r;
  assign rem       = (end_pos >= ops_after) ? end_pos - ops_after : '0;

  always_comb begin
    res_match.part_start  = RES_W'(ops_r);
    res_match.part_length = RES_W'(end_pos - len_ext - ops_r);
    res_match.last_part   = 1'b0;
    res_fin.part_start    = RES_W'(ops_after);
    res_fin.part_length   = RES_W'(rem);
    res_fin.last_part     = 1'b1;
  end

  always_comb begin
    push_c  = '0;
    pos_nxt = pos_r;
    ops_nxt = ops_r;
    if (len_eff == '0) begin
      // Every byte is a part of its own.
      push_c.n                    = 2'd1;
      push_c.res0.part_start      = RES_W'(pos_r);
      push_c.res0.part_length     = RES_W'(1);
      push_c.res0.last_part       = final_byte;
      push_c.res1                 = res_fin;
      ops_nxt                     = end_pos;
    end else begin
      push_c.n    = 2'(sep_hit) + 2'(final_byte);
      push_c.res0 = sep_hit ? res_match : res_fin;
      push_c.res1 = res_fin;
      ops_nxt     = ops_after;
    end
    pos_nxt = end_pos;
    if (final_byte) begin
      pos_nxt = '0;
      ops_nxt = '0;
    end
    if (!item_vld) begin
      push_c.n = 2'd0;
    end
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ops_r <= '0;
      for (int k = 0; k < SEP_MAX; k++) begin
        win_r[k] <= '0;
      end
    end else if (item_vld) begin
      pos_r <= pos_nxt;
      ops_r <= ops_nxt;
      for (int k = 0; k < SEP_MAX; k++) begin
        win_r[k] <= final_byte ? '0 : win_nxt[k];
      end
    end
  end

  // The open part never starts past the current position.
  a_ops_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ops_r <= pos_r)
    else $error("open part start beyond byte position");

  // A final byte returns the string state to its start.
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld && final_byte) |=> (pos_r == '0 && ops_r == '0))
    else $error("state not cleared after final byte");

  // Two results only come from a separator closing on a final byte.
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (final_byte && sep_hit && push.res1.last_part))
    else $error("unexpected pair of results");

endmodule

### design/sfs_result_fifo.sv
// ----------------------------------------------------------------------------
// sfs_result_fifo: result queue
// Takes zero, one or two results per cycle from the split core and hands
// them out one transfer at a time in order.
// ----------------------------------------------------------------------------
module sfs_result_fifo
  import sfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    not_empty,
  output logic    space
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [FIFO_AW-1:0]   wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + 1'b1;
  assign head       = mem[rd_ptr_r];
  assign not_empty  = (count_r != '0);
  // Room for the largest burst from one byte.
  assign space      = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + FIFO_CW'(push.n) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (count_r <= FIFO_CW'(FIFO_DEPTH - 2)))
    else $error("result queue written without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("result queue read while empty");

endmodule

### tb/separator_field_splitter_checker.sv
// ----------------------------------------------------------------------------
// separator_field_splitter_checker: scoreboard for the separator splitter
// Follows register writes and byte transfers, works out the parts that each
// byte closes, and compares every part transfer against the oldest one due.
// ----------------------------------------------------------------------------
module separator_field_splitter_checker
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  in_final_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [RES_W-1:0]      out_part_start,
  input  logic [RES_W-1:0]      out_part_length,
  input  logic                  out_last_part,
  output int                    mismatch_count,
  output int                    expected_left,
  output int                    parts_checked
);

  localparam int SEP_MAX  = SEP_MAX_DEF;
  localparam int OFFSET_W = OFFSET_W_DEF;
  localparam logic [63:0] OFFSET_TOP = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - OFFSET_W);

  logic [CFG_DATA_W-1:0] sep_bytes;
  logic [LEN_W-1:0]      sep_len;
  logic [BYTE_W-1:0]     window [8];
  logic [63:0]           position;
  logic [63:0]           open_start;
  result_t               parts_due [$];
  int                    fails;
  int                    seen;

  function automatic result_t make_part(logic [63:0] start, logic [63:0] len, logic last);
    result_t r;
    r.part_start  = start[RES_W-1:0];
    r.part_length = len[RES_W-1:0];
    r.last_part   = last;
    return r;
  endfunction

  task automatic clear_string();
    int a;
    for (a = 0; a < 8; a++) window[a] = '0;
    position   = '0;
    open_start = '0;
  endtask

  // Works out the parts closed by one byte and queues them in order.
  task automatic split_byte(input logic [BYTE_W-1:0] b, input logic fin);
    int          n;
    int          a;
    int          j;
    logic [63:0] here;
    logic [63:0] end_pos;
    logic        hit;
    n = (sep_len > SEP_MAX) ? SEP_MAX : int'(sep_len);
    for (a = 7; a > 0; a--) window[a] = window[a-1];
    window[0] = b;
    here    = position;
    end_pos = (here >= OFFSET_TOP) ? OFFSET_TOP : here + 1;
    position = end_pos;

    if (n == 0) begin
      parts_due.push_back(make_part(here, 64'd1, fin));
      open_start = end_pos;
      if (fin) clear_string();
    end else begin
      // The separator must lie wholly inside the open part.
      if (open_start <= end_pos && end_pos - open_start >= n && here < OFFSET_TOP) begin
        hit = 1'b1;
        for (j = 0; j < n; j++) begin
          if (window[(n - 1 - j) & 7] != sep_bytes[8*j +: 8]) hit = 1'b0;
        end
        if (hit) begin
          parts_due.push_back(make_part(open_start, end_pos - n - open_start, 1'b0));
          open_start = end_pos;
        end
      end
      if (fin) begin
        parts_due.push_back(make_part(open_start,
                                      (end_pos >= open_start) ? end_pos - open_start : 64'd0,
                                      1'b1));
        clear_string();
      end
    end
  endtask

  task automatic check_part();
    result_t want;
    if (parts_due.size() == 0) begin
      fails++;
      $display("%0t: unexpected part start %0d length %0d last %0b", $time,
               out_part_start, out_part_length, out_last_part);
    end else begin
      want = parts_due.pop_front();
      seen++;
      if (out_part_start !== want.part_start) begin
        fails++;
        $display("%0t: part_start expected %0d, got %0d", $time,
                 want.part_start, out_part_start);
      end
      if (out_part_length !== want.part_length) begin
        fails++;
        $display("%0t: part_length expected %0d, got %0d", $time,
                 want.part_length, out_part_length);
      end
      if (out_last_part !== want.last_part) begin
        fails++;
        $display("%0t: last_part expected %0b, got %0b", $time,
                 want.last_part, out_last_part);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes = '0;
      sep_len   = LEN_W'(1);
      clear_string();
      parts_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEP_BYTES: sep_bytes = cfg_wdata;
          CFG_SEP_LEN:   sep_len   = cfg_wdata[LEN_W-1:0];
          default:       ;
        endcase
      end
      if (in_valid && !in_stall) split_byte(in_data_byte, in_final_byte);
      if (out_valid && !out_stall) check_part();
    end
    mismatch_count <= fails;
    expected_left  <= parts_due.size();
    parts_checked  <= seen;
  end

endmodule

### tb/separator_field_splitter_core_test.sv
// ----------------------------------------------------------------------------
// separator_field_splitter_core_test: stimulus and verdict for the splitter
// Writes separator settings between idle phases, feeds short directed strings
// and then random strings built around the separator, with random gaps and
// output stalls, two long output hold-offs, and a checker doing the compares.
// ----------------------------------------------------------------------------
module separator_field_splitter_core_test;
  import sfs_pkg::*;

  localparam int RANDOM_BYTES  = 1250;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  in_final_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [RES_W-1:0]      out_part_start;
  logic [RES_W-1:0]      out_part_length;
  logic                  out_last_part;
  int                    mismatch_count;
  int                    expected_left;
  int                    parts_checked;

  bit          tx_gaps;
  bit          rx_stalls;
  bit          hold_req;
  int          bytes_sent;
  int          strings_sent;
  int          settings_used;
  int          long_holds;
  int          cycle_count;
  logic [63:0] cur_sep;
  int          cur_len;

  separator_field_splitter_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_part_start  (out_part_start),
    .out_part_length (out_part_length),
    .out_last_part   (out_last_part)
  );

  separator_field_splitter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_part_start  (out_part_start),
    .out_part_length (out_part_length),
    .out_last_part   (out_last_part),
    .mismatch_count  (mismatch_count),
    .expected_left   (expected_left),
    .parts_checked   (parts_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    int gap;
    gap = idle_len(tx_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    strings_sent++;
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] sep, input int len);
    put_reg(CFG_SEP_BYTES, sep);
    put_reg(CFG_SEP_LEN, CFG_DATA_W'(len));
    cfg_wr_en <= 1'b0;
    cur_sep = sep;
    cur_len = (len > SEP_MAX_DEF) ? SEP_MAX_DEF : len;
    settings_used++;
  endtask

  // Stop offering bytes and wait until every part due has been taken, then
  // let the pipeline drain while no byte is offered.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Builds a string from whole separators, separator prefixes, single
  // separator bytes and arbitrary bytes; a few strings are pure noise.
  task automatic send_string();
    logic [BYTE_W-1:0] q [$];
    int target;
    int pick;
    int k;
    int cut;
    bit noise;
    target = $urandom_range(1, 24);
    noise  = ($urandom_range(0, 9) == 0);
    while (q.size() < target) begin
      pick = noise ? 9 : $urandom_range(0, 9);
      if (pick <= 3 && cur_len > 0) begin
        for (k = 0; k < cur_len; k++) q.push_back(cur_sep[8*k +: 8]);
      end else if (pick <= 5 && cur_len > 1) begin
        cut = $urandom_range(1, cur_len - 1);
        for (k = 0; k < cut; k++) q.push_back(cur_sep[8*k +: 8]);
      end else if (pick <= 7 && cur_len > 0) begin
        k = $urandom_range(0, cur_len - 1);
        q.push_back(cur_sep[8*k +: 8]);
      end else begin
        q.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end
    for (k = 0; k < q.size(); k++) send_byte(q[k], k == q.size() - 1);
    strings_sent++;
  endtask

  // Output side: random stalls, and a long hold-off whenever one is asked for.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        long_holds++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = idle_len(rx_stalls);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d parts still due",
             CYCLE_LIMIT, expected_left);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          phase;
    int          phase_end;
    int          len;
    logic [63:0] sep;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_SEP_BYTES;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_final_byte = 1'b0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    hold_req      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings split on a single zero byte, including an empty first
    // part and a separator on the final byte that leaves an empty remainder.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAB, 1'b1);
    strings_sent += 2;
    settle();

    configure(64'h6261, 2);
    send_text("aabab");
    settle();

    // Overlapping candidates: matches are leftmost and never share bytes.
    configure(64'h6161, 2);
    send_text("aaaaa");
    settle();

    configure({$urandom, $urandom}, 0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    strings_sent++;
    settle();

    // A full width separator that makes up the whole string.
    configure(64'h0123_4567_89AB_CDEF, 8);
    for (int k = 0; k < 8; k++) send_byte(cur_sep[8*k +: 8], k == 7);
    strings_sent++;
    settle();

    phase = 0;
    while (bytes_sent < 25 + RANDOM_BYTES) begin
      sep = {$urandom, $urandom};
      case (phase)
        0:       len = 0;
        1:       len = 1;
        2:       begin sep = 64'hFFFF_FFFF_FFFF_FFFF; len = 8; end
        3:       begin sep = 64'h0; len = 9; end
        4:       len = 15;
        5:       len = 3;
        default: len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8);
      endcase
      configure(sep, len);
      if (phase == 1) {tx_gaps, rx_stalls} = 2'b00;
      else            {tx_gaps, rx_stalls} = 2'($urandom_range(0, 3));
      if (phase == 0 || phase == 7) hold_req = 1'b1;
      phase_end = bytes_sent + $urandom_range(40, 120);
      while (bytes_sent < phase_end) send_string();
      settle();
      phase++;
    end

    $display("Sent %0d bytes in %0d strings under %0d separator settings; %0d parts checked.",
             bytes_sent, strings_sent, settings_used, parts_checked);
    $display("The output was held off %0d times for %0d cycles while bytes kept coming.",
             long_holds, HOLD_CYCLES);
    if (expected_left != 0) $display("%0d expected parts never arrived", expected_left);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
design/sfs_pkg.sv
design/sfs_split_core.sv
design/sfs_result_fifo.sv
design/separator_field_splitter_core.sv
tb/separator_field_splitter_checker.sv
tb/separator_field_splitter_core_test.sv
